[rtl/cascaded_biquad_iir_filter_macros.svh]
// assertion macros for the cascaded biquad filter
`ifndef CASCADED_BIQUAD_IIR_FILTER_MACROS_SVH
`define CASCADED_BIQUAD_IIR_FILTER_MACROS_SVH
// property checked on every rising clock edge outside reset
`define CBQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// property checked on every rising clock edge, reset included
`define CBQ_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

[rtl/cbq_pkg.sv]
// package: constants, types and helpers of the cascaded biquad filter
`timescale 1ns / 1ps
package cbq_pkg;
   localparam int MaxSections = 4;
   localparam int DefNumSections = 4;
   localparam int DefFractionBits = 14;
   localparam int CoefBits = 17;
   localparam int SampleBits = 16;
   localparam int AccBits = 32;
   localparam int FeedbackBits = 51;
   localparam int FeedforwardBits = 34;
   localparam int CsrIndexBits = 3;
   localparam int CsrDataBits = 51;
   localparam int SerBits = 5;
   localparam logic [FeedbackBits-1:0] FeedbackReset = 51'd16384;

   // terms of one section, in working order
   typedef enum logic [2:0] {
      TERM_A = 3'd0,
      TERM_B = 3'd1,
      TERM_C = 3'd2,
      TERM_D = 3'd3,
      TERM_E = 3'd4
   } term_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_MUL  = 2'd1,
      ST_DONE = 2'd2
   } state_type;
endpackage

[rtl/cascaded_biquad_iir_filter.sv]
// cascaded biquad filter: top level with a bit-serial shared multiplier
// sequence: 5 products per section, each a load step, a bit-serial multiply and an
// accumulate step, for every section in turn from accept to result
// items: one at a time, a new one is not accepted before the last result is produced
// a new item is taken only once the waiting result has left the output register
// reset: synchronous active high; bypass coefficients and all delays zero
`timescale 1ns / 1ps
`include "cascaded_biquad_iir_filter_macros.svh"
module cascaded_biquad_iir_filter #(
   parameter int NUM_SECTIONS = cbq_pkg::DefNumSections,
   parameter int FRACTION_BITS = cbq_pkg::DefFractionBits
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic signed [cbq_pkg::SampleBits-1:0]     req_sample,
   output logic                                      rsp_valid,
   input  logic                                      rsp_ready,
   output logic signed [cbq_pkg::SampleBits-1:0]     rsp_filtered_sample,
   input  logic                                      csr_write,
   input  logic [cbq_pkg::CsrIndexBits-1:0]          csr_index,
   input  logic [cbq_pkg::CsrDataBits-1:0]           csr_data
);
   import cbq_pkg::*;

   localparam int DelayBits = AccBits - FRACTION_BITS;
   localparam int SecBits = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;
   localparam logic [SecBits-1:0] LastSec = SecBits'(NUM_SECTIONS - 1);

   // coefficient registers
   logic [FeedbackBits-1:0]    fb_ff [MaxSections];
   logic [FeedforwardBits-1:0] ffw_ff [MaxSections];
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MaxSections; i++) begin
            fb_ff[i]  <= FeedbackReset;
            ffw_ff[i] <= '0;
         end
      end else if (csr_write) begin
         if (csr_index[0]) begin
            ffw_ff[csr_index[2:1]] <= csr_data[FeedforwardBits-1:0];
         end else begin
            fb_ff[csr_index[2:1]] <= csr_data;
         end
      end
   end

   // state and datapath registers
   state_type                  state_ff, state_in;
   logic [SecBits-1:0]         sec_ff, sec_in;
   term_type                   term_ff, term_in;
   logic [SerBits-1:0]         bit_ff, bit_in;
   logic [AccBits-1:0]         x_ff, x_in;
   logic [AccBits-1:0]         mcand_ff, mcand_in;
   logic [AccBits-1:0]         mplier_ff, mplier_in;
   logic [AccBits-1:0]         prod_ff, prod_in;
   logic [AccBits-1:0]         w_ff, w_in;
   logic [AccBits-1:0]         y_ff, y_in;
   logic [DelayBits-1:0]       w1_ff [MaxSections];
   logic [DelayBits-1:0]       w2_ff [MaxSections];
   logic                       dly_we;
   logic                       busy_ff, busy_in;
   logic                       out_valid_ff, out_valid_in;
   logic [SampleBits-1:0]      out_ff, out_in;

   // operand selection for the current term
   logic [FeedbackBits-1:0]    fb_sel;
   logic [FeedforwardBits-1:0] ffw_sel;
   logic [CoefBits-1:0]        coef_sel;
   logic [AccBits-1:0]         data_sel;
   logic [AccBits-1:0]         w1_ext, w2_ext, w_sh, y_sh;
   always_comb begin
      fb_sel  = fb_ff[2'(sec_ff)];
      ffw_sel = ffw_ff[2'(sec_ff)];
      w1_ext  = AccBits'($signed(w1_ff[2'(sec_ff)]));
      w2_ext  = AccBits'($signed(w2_ff[2'(sec_ff)]));
      case (term_ff)
         TERM_A:  begin coef_sel = fb_sel[CoefBits-1:0];               data_sel = x_ff;   end
         TERM_B:  begin coef_sel = fb_sel[2*CoefBits-1:CoefBits];      data_sel = w1_ext; end
         TERM_C:  begin coef_sel = fb_sel[3*CoefBits-1:2*CoefBits];    data_sel = w2_ext; end
         TERM_D:  begin coef_sel = ffw_sel[CoefBits-1:0];              data_sel = w1_ext; end
         TERM_E:  begin coef_sel = ffw_sel[2*CoefBits-1:CoefBits];     data_sel = w2_ext; end
         default: begin coef_sel = '0;                                 data_sel = '0;     end
      endcase
   end

   // accumulate the finished product into w and y
   logic [AccBits-1:0] w_acc, y_acc;
   always_comb begin
      w_acc = w_ff;
      y_acc = y_ff;
      case (term_ff)
         TERM_A:  w_acc = prod_ff;
         TERM_B:  w_acc = w_ff - prod_ff;
         TERM_C:  w_acc = w_ff - prod_ff;
         TERM_D:  y_acc = w_ff + prod_ff;
         TERM_E:  y_acc = y_ff + prod_ff;
         default: ;
      endcase
      w_sh = $signed(w_ff) >>> FRACTION_BITS;
      y_sh = $signed(y_acc) >>> FRACTION_BITS;
   end

   // sequencer: one product bit per cycle while in the multiply state, shift-and-add
   always_comb begin
      state_in     = state_ff;
      sec_in       = sec_ff;
      term_in      = term_ff;
      bit_in       = bit_ff;
      x_in         = x_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      prod_in      = prod_ff;
      w_in         = w_ff;
      y_in         = y_ff;
      dly_we       = 1'b0;
      busy_in      = busy_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      req_ready    = (state_ff == ST_IDLE);
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               x_in     = AccBits'($signed(req_sample));
               sec_in   = '0;
               term_in  = TERM_A;
               state_in = ST_DONE;
               busy_in  = 1'b1;
            end
         end
         ST_DONE: begin
            // load the operands of the current term
            mcand_in  = data_sel;
            mplier_in = AccBits'($signed(coef_sel));
            prod_in   = '0;
            bit_in    = '0;
            state_in  = ST_MUL;
         end
         ST_MUL: begin
            if (mplier_ff[0]) begin
               prod_in = prod_ff + mcand_ff;
            end
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            bit_in    = bit_ff + 1'b1;
            if (bit_ff == SerBits'(AccBits - 1)) begin
               // product complete next cycle: fold in via prod_in
               state_in = ST_DONE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      // when the product just finished, accumulate (prod_ff final at entry to DONE)
      if (state_ff == ST_DONE && busy_ff && bit_ff == SerBits'(AccBits - 1)) begin
         w_in = w_acc;
         y_in = y_acc;
         bit_in = '0;
         if (term_ff == TERM_E) begin
            dly_we = 1'b1;
            x_in   = AccBits'($signed(y_sh[SampleBits-1:0]));
            term_in = TERM_A;
            if (sec_ff == LastSec) begin
               out_in       = y_sh[SampleBits-1:0];
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
               busy_in      = 1'b0;
            end else begin
               sec_in = sec_ff + 1'b1;
               state_in = ST_DONE;
               // operands load next cycle with the new section
               bit_in = '0;
               mplier_in = mplier_ff;
               mcand_in = mcand_ff;
            end
         end else begin
            term_in  = term_type'(term_ff + 3'd1);
            state_in = ST_DONE;
            mplier_in = mplier_ff;
            mcand_in = mcand_ff;
         end
         if (state_in == ST_DONE) begin
            // next visit to DONE loads operands
            bit_in = '0;
         end
         if (out_valid_ff && !(rsp_ready) && state_in == ST_IDLE) begin
            out_valid_in = 1'b1;
         end
      end
      // in idle, accept no new item while a waiting result is not yet taken
      if (state_ff == ST_IDLE) begin
         req_ready = !(out_valid_ff && !rsp_ready) ? 1'b1 : 1'b0;
         if (!req_ready) begin
            state_in = ST_IDLE;
            busy_in  = busy_ff;
         end
      end
   end

   // bit counter marks a pending fold: DONE with bit 31 accumulates, otherwise loads
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sec_ff       <= '0;
         term_ff      <= TERM_A;
         bit_ff       <= '0;
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < MaxSections; i++) begin
            w1_ff[i] <= '0;
            w2_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         sec_ff       <= sec_in;
         term_ff      <= term_in;
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
         if (state_ff == ST_MUL && bit_ff == SerBits'(AccBits - 1)) begin
            bit_ff <= bit_ff;
         end else begin
            bit_ff <= bit_in;
         end
         if (dly_we) begin
            w2_ff[2'(sec_ff)] <= w1_ff[2'(sec_ff)];
            w1_ff[2'(sec_ff)] <= w_sh[DelayBits-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff      <= x_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      prod_ff   <= prod_in;
      w_ff      <= w_in;
      y_ff      <= y_in;
      out_ff    <= out_in;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_filtered_sample = out_ff;

   // checks
   `CBQ_ASSERT(a_no_accept_busy, clock, reset, (state_ff != ST_IDLE) |-> !req_ready, "item accepted while busy")
   `CBQ_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_filtered_sample)), "waiting result changed")
   `CBQ_ASSERT(a_sec_range, clock, reset, sec_ff <= LastSec, "section counter out of range")
   `CBQ_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (state_ff == ST_IDLE && !rsp_valid), "not idle after reset")
endmodule

[tb/tb_top.sv]
// testbench of the cascaded biquad filter: directed and random samples checked against a predictor
`timescale 1ns / 1ps
module tb_top;
   import cbq_pkg::*;

   localparam int NSec = DefNumSections;
   localparam int Frac = DefFractionBits;
   localparam int ItemCycles = NSec * 170 + 1;
   localparam int NRegs = 2 * MaxSections;
   localparam longint LimitCycles = 64'd8_000_000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [SampleBits-1:0] req_sample = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [SampleBits-1:0] rsp_filtered_sample;
   logic csr_write = 1'b0;
   logic [CsrIndexBits-1:0] csr_index = '0;
   logic [CsrDataBits-1:0] csr_data = '0;

   // predictor copy of coefficients and delays
   logic [CsrDataBits-1:0] coef_shadow [NRegs];
   logic [31:0] delay_shadow [NRegs];
   logic signed [SampleBits-1:0] expected_samples [$];

   int mismatches = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   longint cycles = 0;

   cascaded_biquad_iir_filter u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_sample(req_sample),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_filtered_sample(rsp_filtered_sample),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LimitCycles) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic logic [31:0] coef_term(logic [CsrDataBits-1:0] r, int pos);
      logic [CoefBits-1:0] f;
      f = r[pos*CoefBits +: CoefBits];
      return {{(32-CoefBits){f[CoefBits-1]}}, f};
   endfunction

   // run one sample through the cascade, updating the delay copy
   function automatic logic signed [SampleBits-1:0] filter_sample(
         logic signed [SampleBits-1:0] s);
      logic [31:0] x, w, y, w1, w2;
      logic [31:0] ta, tb, tc, td, te;
      x = {{16{s[15]}}, s};
      for (int k = 0; k < NSec; k++) begin
         ta = coef_term(coef_shadow[2*k], 0);
         tb = coef_term(coef_shadow[2*k], 1);
         tc = coef_term(coef_shadow[2*k], 2);
         td = coef_term(coef_shadow[2*k+1], 0);
         te = coef_term(coef_shadow[2*k+1], 1);
         w1 = delay_shadow[2*k];
         w2 = delay_shadow[2*k+1];
         w = ta*x - tb*w1 - tc*w2;
         y = w + td*w1 + te*w2;
         delay_shadow[2*k+1] = w1;
         delay_shadow[2*k] = $unsigned($signed(w) >>> Frac);
         y = $unsigned($signed(y) >>> Frac);
         x = {{16{y[15]}}, y[15:0]};
      end
      return x[15:0];
   endfunction

   // result checker and receiver stalls
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_samples.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected item: got %0d", rsp_filtered_sample);
         end else begin
            if (rsp_filtered_sample !== expected_samples[0]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("filtered_sample mismatch: expected %0d got %0d",
                           expected_samples[0], rsp_filtered_sample);
            end
            void'(expected_samples.pop_front());
         end
      end
   end

   always @(negedge clock)
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);

   task automatic send_sample(logic signed [SampleBits-1:0] s);
      // valid drops for a cycle between items
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_valid <= 1'b1;
      req_sample <= s;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_samples.push_back(filter_sample(s));
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic drain();
      while (expected_samples.size() != 0) @(negedge clock);
      repeat (ItemCycles + 20) @(negedge clock);
   endtask

   task automatic write_reg(logic [CsrIndexBits-1:0] idx, logic [CsrDataBits-1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      if (idx[0]) coef_shadow[idx] = val & {{(CsrDataBits-FeedforwardBits){1'b0}},
                                          {FeedforwardBits{1'b1}}};
      else coef_shadow[idx] = val;
      @(negedge clock);
      csr_write <= 1'b0;
      // one quiet cycle before the next write
      @(negedge clock);
   endtask

   function automatic logic [CoefBits-1:0] rnd_coef();
      return CoefBits'($urandom);
   endfunction

   // load one section: feedback terms a, b, c and feedforward terms d, e
   task automatic load_section(int k, logic [CoefBits-1:0] a, logic [CoefBits-1:0] b,
         logic [CoefBits-1:0] c, logic [CoefBits-1:0] d, logic [CoefBits-1:0] e);
      write_reg(CsrIndexBits'(2*k), {c, b, a});
      write_reg(CsrIndexBits'(2*k+1), {{(CsrDataBits-34){1'b0}}, e, d});
   endtask

   // bypass coefficients, extremes of the sample
   task automatic test_bypass_extremes();
      logic signed [SampleBits-1:0] vals [8] = '{16'sh7fff, -16'sh8000, 0, 1, -1,
                                                16'sh5555, -16'sh5556, 16'sh1234};
      foreach (vals[i]) send_sample(vals[i]);
      drain();
   endtask

   // full-scale and overflowing coefficients on every section
   task automatic test_coef_extremes();
      for (int k = 0; k < NSec; k++)
         load_section(k, 17'h0ffff, 17'h10000, 17'h0ffff, 17'h10000, 17'h0ffff);
      // wide data bits above the feedforward register of section 0 are ignored
      write_reg(CsrIndexBits'(1), {CsrDataBits{1'b1}});
      send_sample(16'sh7fff); send_sample(-16'sh8000); send_sample(16'sh7fff);
      send_sample(-16'sh8000); send_sample(0); send_sample(-1); send_sample(1);
      drain();
      for (int k = 0; k < NSec; k++)
         load_section(k, 17'h10000, 17'h0ffff, 17'h10000, 17'h0ffff, 17'h10000);
      for (int i = 0; i < 8; i++) send_sample(i[0] ? 16'sh7fff : -16'sh8000);
      drain();
   endtask

   // random coefficients and samples under one idling mode
   task automatic test_random_phase(int idle, int stall, int n);
      send_idle_pct = idle;
      recv_stall_pct = stall;
      for (int k = 0; k < NSec; k++) begin
         if ($urandom_range(3) == 0)
            load_section(k, rnd_coef(), rnd_coef(), rnd_coef(), rnd_coef(), rnd_coef());
         else
            load_section(k, 17'(16384 + $urandom_range(4095) - 2048),
                         17'($urandom_range(2047) - 1024), 17'($urandom_range(2047) - 1024),
                         rnd_coef(), rnd_coef());
      end
      for (int i = 0; i < n; i++) begin
         send_sample(SampleBits'($urandom));
         // halfway through, hold off until every result is back
         if (i == n / 2) while (expected_samples.size() != 0) @(negedge clock);
      end
      drain();
   endtask

   initial begin
      for (int i = 0; i < NRegs; i++) begin
         coef_shadow[i] = i[0] ? '0 : FeedbackReset;
         delay_shadow[i] = '0;
      end
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_bypass_extremes();
      test_coef_extremes();
      test_random_phase(0, 0, 410);
      test_random_phase(51, 0, 410);
      test_random_phase(0, 51, 410);
      test_random_phase(21, 21, 400);
      if (mismatches == 0 && expected_samples.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
